@@ sv/lfra_pkg.sv @@
// Shared types, widths and codes of the lowest free room allocator.
package lfra_pkg;

  localparam int CUST_ID_W         = 10;
  localparam int ROOM_W            = 9;
  localparam int STATUS_W          = 2;
  localparam int DEF_MAX_ROOMS     = 256;
  localparam int DEF_MAX_CUSTOMERS = 1024;
  localparam logic [ROOM_W-1:0] LIMIT_RESET = ROOM_W'(256);

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_DEPART = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUOT,
    S_READ,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic quot_en;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

  // True when the customer id reduction needs a reciprocal multiply.
  function automatic logic needs_quot(input int c);
    return (c < 512) && ((c & (c - 1)) != 0);
  endfunction

endpackage

@@ sv/lfra_if.sv @@
// Valid/ready channel interfaces for event beats and result beats.
interface lfra_in_if import lfra_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [CUST_ID_W-1:0] customer_id;

  modport source (output valid, output action, output customer_id, input ready);
  modport sink (input valid, input action, input customer_id, output ready);
endinterface

interface lfra_out_if import lfra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROOM_W-1:0]   room;
  logic [ROOM_W-1:0]   occupancy;
  logic [ROOM_W-1:0]   peak;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output room, output occupancy, output peak,
                  output status, input ready);
  modport sink (input valid, input room, input occupancy, input peak,
                input status, output ready);
endinterface

@@ sv/lfra_ctrl.sv @@
// Controller state machine that sequences clearing, lookup and commit of each beat.
module lfra_ctrl import lfra_pkg::*; #(
  parameter int MAX_CUSTOMERS = DEF_MAX_CUSTOMERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  localparam logic NEEDS_QUOT = needs_quot(MAX_CUSTOMERS);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = NEEDS_QUOT ? S_QUOT : S_READ;
      end
      S_QUOT:  state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_QUOT:  cmd.quot_en = 1'b1;
      S_READ:  cmd.rd_en = 1'b1;
      S_EXEC:  cmd.commit = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/lfra_dp.sv @@
// Datapath with the free room map, customer table, counters and result register.
module lfra_dp import lfra_pkg::*; #(
  parameter int MAX_ROOMS     = DEF_MAX_ROOMS,
  parameter int MAX_CUSTOMERS = DEF_MAX_CUSTOMERS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_sts_t              sts,
  input  logic                 in_action,
  input  logic [CUST_ID_W-1:0] in_customer_id,
  input  logic                 cfg_wr_en,
  input  logic [ROOM_W-1:0]    cfg_wr_data,
  output logic [ROOM_W-1:0]    res_room,
  output logic [ROOM_W-1:0]    res_occupancy,
  output logic [ROOM_W-1:0]    res_peak,
  output logic [STATUS_W-1:0]  res_status
);

  localparam int RW   = $clog2(MAX_ROOMS);
  localparam int CW   = $clog2(MAX_ROOMS + 1);
  localparam int CIW  = $clog2(MAX_CUSTOMERS);
  localparam int CMPW = (RW > ROOM_W) ? RW : ROOM_W;

  logic [ROOM_W-1:0]    room_limit_r;
  logic [MAX_ROOMS-1:0] free_map_r;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [CW-1:0]        peak_r, peak_nxt;
  logic [CIW-1:0]       clr_cnt_r;
  logic                 action_r;
  logic [CUST_ID_W-1:0] cid_r;
  logic [CIW-1:0]       idx_c;
  logic [CIW-1:0]       idx_r;
  logic [RW:0]          cust_mem [MAX_CUSTOMERS];
  logic [RW:0]          mem_q_r;
  logic                 mem_we;
  logic [CIW-1:0]       mem_waddr;
  logic [RW:0]          mem_wdata;
  logic [MAX_ROOMS-1:0] low_onehot;
  logic [RW-1:0]        low_idx_c, low_idx_r;
  logic                 low_any_r;
  logic                 present;
  logic [RW-1:0]        stored;
  logic                 grant_ok;
  logic                 do_grant, do_free;
  logic [ROOM_W-1:0]    room_c;
  status_t              status_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      room_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + CIW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == CIW'(MAX_CUSTOMERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      cid_r    <= in_customer_id;
    end
  end

  if (MAX_CUSTOMERS >= (1 << CUST_ID_W)) begin : g_id_wide
    assign idx_c = CIW'(cid_r);
  end else if ((MAX_CUSTOMERS & (MAX_CUSTOMERS - 1)) == 0) begin : g_id_mask
    assign idx_c = cid_r[CIW-1:0];
  end else if (!needs_quot(MAX_CUSTOMERS)) begin : g_id_sub
    assign idx_c = (cid_r >= CUST_ID_W'(MAX_CUSTOMERS)) ?
                   CIW'(cid_r - CUST_ID_W'(MAX_CUSTOMERS)) : CIW'(cid_r);
  end else begin : g_id_quot
    localparam int SH = CUST_ID_W + $clog2(MAX_CUSTOMERS);
    localparam int RECIP = ((1 << SH) + MAX_CUSTOMERS - 1) / MAX_CUSTOMERS;
    localparam int MW = $clog2(RECIP + 1);
    localparam int PW = CUST_ID_W + MW;
    logic [CUST_ID_W-1:0] q_r;
    logic [PW-1:0]        prod;
    logic [CUST_ID_W:0]   rem;
    assign prod = PW'(cid_r) * PW'(RECIP);
    always_ff @(posedge clk) begin
      if (cmd.quot_en) begin
        q_r <= CUST_ID_W'(prod >> SH);
      end
    end
    assign rem = {1'b0, cid_r} - (CUST_ID_W + 1)'(q_r * CUST_ID_W'(MAX_CUSTOMERS));
    assign idx_c = (rem >= (CUST_ID_W + 1)'(MAX_CUSTOMERS)) ?
                   CIW'(rem - (CUST_ID_W + 1)'(MAX_CUSTOMERS)) : CIW'(rem);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      idx_r   <= idx_c;
      mem_q_r <= cust_mem[idx_c];
    end
    if (mem_we) begin
      cust_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    low_onehot = free_map_r & (~free_map_r + MAX_ROOMS'(1));
    low_idx_c  = '0;
    for (int i = 0; i < MAX_ROOMS; i++) begin
      if (low_onehot[i]) low_idx_c = low_idx_c | RW'(i);
    end
  end

  always_ff @(posedge clk) begin
    low_idx_r <= low_idx_c;
    low_any_r <= |free_map_r;
  end

  assign present  = mem_q_r[RW];
  assign stored   = mem_q_r[RW-1:0];
  assign grant_ok = low_any_r && (CMPW'(low_idx_r) < CMPW'(room_limit_r));

  always_comb begin
    room_c   = '0;
    status_c = STS_OK;
    occ_nxt  = occ_r;
    peak_nxt = peak_r;
    do_grant = 1'b0;
    do_free  = 1'b0;
    if (action_r == ACT_ARRIVE) begin
      if (present) begin
        room_c = ROOM_W'({1'b0, stored} + (RW + 1)'(1));
      end else if (grant_ok) begin
        do_grant = 1'b1;
        room_c   = ROOM_W'({1'b0, low_idx_r} + (RW + 1)'(1));
        occ_nxt  = occ_r + CW'(1);
        if (occ_nxt > peak_r) peak_nxt = occ_nxt;
      end else begin
        status_c = STS_FULL;
      end
    end else begin
      if (present) begin
        do_free = 1'b1;
        room_c  = ROOM_W'({1'b0, stored} + (RW + 1)'(1));
        if (occ_r != '0) occ_nxt = occ_r - CW'(1);
      end else begin
        status_c = STS_ABSENT;
      end
    end
  end

  always_comb begin
    mem_we    = cmd.clr_en || (cmd.commit && (do_grant || do_free));
    mem_waddr = cmd.clr_en ? clr_cnt_r : idx_r;
    mem_wdata = (cmd.commit && do_grant) ? {1'b1, low_idx_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= '1;
      occ_r      <= '0;
      peak_r     <= '0;
    end else if (cmd.commit) begin
      if (do_grant) free_map_r[low_idx_r] <= 1'b0;
      if (do_free) free_map_r[stored] <= 1'b1;
      occ_r  <= occ_nxt;
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_room      <= room_c;
      res_occupancy <= ROOM_W'(occ_nxt);
      res_peak      <= ROOM_W'(peak_nxt);
      res_status    <= status_c;
    end
  end

endmodule

@@ sv/lowest_free_room_allocator_core.sv @@
// Top level of the lowest free room allocator: controller, datapath and channels.
//
//   Port       Direction  Beat contents
//   in_ch      sink       action, customer_id
//   out_ch     source     room, occupancy, peak, status
//   cfg_*      input      room_limit write, taken on any cycle with cfg_wr_en
//
// The result of an event beat is registered in the execute step, after the read step
// and, when MAX_CUSTOMERS is below 512 and not a power of two, a quotient step. The
// controller steps through idle, read and execute, and the quotient step in that case,
// so a new event beat is taken only once the last one has executed; the registered
// read of the customer table and, in that case, the reciprocal multiply set this pace.
// After reset a clearing pass sweeps all MAX_CUSTOMERS entries (1024 by default)
// of the customer table before the first event beat is taken.
// A result waiting on a stalled out_ch does not block the next event beat, but that
// beat holds in its execute step until out_ch takes the waiting result.
module lowest_free_room_allocator_core import lfra_pkg::*; #(
  parameter int MAX_ROOMS     = DEF_MAX_ROOMS,
  parameter int MAX_CUSTOMERS = DEF_MAX_CUSTOMERS
) (
  input  logic              clk,
  input  logic              rst_n,
  lfra_in_if.sink           in_ch,
  lfra_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [ROOM_W-1:0] cfg_wr_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lfra_ctrl #(
    .MAX_CUSTOMERS(MAX_CUSTOMERS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfra_dp #(
    .MAX_ROOMS    (MAX_ROOMS),
    .MAX_CUSTOMERS(MAX_CUSTOMERS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_customer_id(in_ch.customer_id),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .res_room      (out_ch.room),
    .res_occupancy (out_ch.occupancy),
    .res_peak      (out_ch.peak),
    .res_status    (out_ch.status)
  );

endmodule
